@@ hw/rtl/pspc_pkg.sv @@
// shared types, widths and codes for the periodic sphere overlap check
package pspc_pkg;

   localparam int MAX_SPHERES_DEF = 256;
   localparam int COORD_W = 24;
   localparam int RADIUS_W = 20;
   localparam int BOX_W = 23;
   localparam int ITEM_W = 3 * COORD_W + RADIUS_W;
   localparam int MAG_W = 24;
   localparam int NUM_W = 26;
   localparam int PROD_W = NUM_W + BOX_W;
   localparam int SQ_W = 2 * MAG_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int RSUM_W = RADIUS_W + 1;
   localparam int RSQ_W = 2 * RSUM_W;
   localparam int IDXO_W = 8;
   localparam logic [BOX_W-1:0] BOX_RESET = 23'd25600;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_HIT = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic REG_BOX_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_I,
      ST_READ_J,
      ST_FETCH_J,
      ST_DIFF,
      ST_WRAP,
      ST_SQUARE,
      ST_COMPARE
   } state_type;

endpackage

@@ hw/rtl/pspc_ram.sv @@
// generic single write, single read ram with registered read data
module pspc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

@@ hw/rtl/pspc_wrap.sv @@
// minimum-image wrap of one axis magnitude: bit-serial divide, multiply, subtract
module pspc_wrap (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [pspc_pkg::MAG_W-1:0]  mag,
   input  logic [pspc_pkg::BOX_W-1:0]  box_len,
   output logic                        done,
   output logic [pspc_pkg::MAG_W-1:0]  wrapped
);
   import pspc_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 2);
   localparam logic [CNT_W-1:0] CNT_MUL = CNT_W'(NUM_W);
   localparam logic [CNT_W-1:0] CNT_SUB = CNT_W'(NUM_W + 1);

   logic              act_ff, act_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [MAG_W-1:0]  mag_ff;
   logic [BOX_W-1:0]  len_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [MAG_W-1:0]  wrapped_ff;
   logic              done_ff;
   logic [MAG_W:0]    rem_sh;
   logic [MAG_W:0]    den;
   logic              ge;
   logic [PROD_W-1:0] mag_ext;

   // one restoring division step on (2m+L)/(2L)
   always_comb begin
      den = {1'b0, len_ff, 1'b0};
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge = (rem_sh >= den);
      rem_in = ge ? MAG_W'(rem_sh - den) : rem_sh[MAG_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
      num_in = {num_ff[NUM_W-2:0], 1'b0};
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (load) begin
         act_in = 1'b1;
         cnt_in = '0;
      end else if (act_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_SUB) begin
            act_in = 1'b0;
         end
      end
      mag_ext = PROD_W'(mag_ff);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
         done_ff <= act_ff && !load && (cnt_ff == CNT_SUB);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= NUM_W'({mag, 1'b0}) + NUM_W'(box_len);
         rem_ff <= '0;
         quo_ff <= '0;
         mag_ff <= mag;
         len_ff <= box_len;
      end else if (act_ff) begin
         if (cnt_ff < CNT_MUL) begin
            num_ff <= num_in;
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end else if (cnt_ff == CNT_MUL) begin
            prod_ff <= PROD_W'(quo_ff * len_ff);
         end else begin
            wrapped_ff <= (prod_ff >= mag_ext) ? MAG_W'(prod_ff - mag_ext)
                                               : MAG_W'(mag_ext - prod_ff);
         end
      end
   end

   assign done = done_ff;
   assign wrapped = wrapped_ff;
endmodule

@@ hw/rtl/periodic_sphere_overlap_check_core.sv @@
// periodic sphere overlap check: item loading, pair walk and result
// Load words are taken one per cycle while busy is low; a last word with a full store
// or fewer than two spheres gives its rsp_valid strobe in the cycle after, no stall.
// Otherwise each pair walks fetch, diff, wrap (with a 26-step divide), square and compare,
// a new row adds a read of entry i, and the result strobe follows in the next cycle.
// Reset clears the count and full flag, sets box_length to 25600, keeps the store.
module periodic_sphere_overlap_check_core #(
   parameter int MAX_SPHERES = pspc_pkg::MAX_SPHERES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [pspc_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [pspc_pkg::COORD_W-1:0]  req_center_y,
   input  logic signed [pspc_pkg::COORD_W-1:0]  req_center_z,
   input  logic [pspc_pkg::RADIUS_W-1:0]        req_radius,
   input  logic                                 req_last_item,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [pspc_pkg::IDXO_W-1:0]          rsp_first_index,
   output logic [pspc_pkg::IDXO_W-1:0]          rsp_second_index,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import pspc_pkg::*;

   localparam int IDX_W = $clog2(MAX_SPHERES);
   localparam int CNT_W = $clog2(MAX_SPHERES + 1);
   localparam int CMP_W = CNT_W + 1;
   localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_SPHERES);

   state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [BOX_W-1:0]    box_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [IDXO_W-1:0]   rsp_first_ff, rsp_first_in;
   logic [IDXO_W-1:0]   rsp_second_ff, rsp_second_in;
   logic [ITEM_W-1:0]   item_i_ff;
   logic [RSUM_W-1:0]   rsum_ff;
   logic [SQ_W-1:0]     sq_ff [3];
   logic [RSQ_W-1:0]    rsq_ff;

   logic                accept, has_room, is_last, cfg_wr;
   logic [CMP_W-1:0]    cnt_next, j_next, i_next2;
   logic                ovf_next;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_raddr;
   logic [ITEM_W-1:0]   mem_wdata, mem_rdata;
   logic                wrap_load;
   logic [MAG_W-1:0]    mag [3];
   logic                done [3];
   logic [MAG_W-1:0]    wrapped [3];
   logic [SUM_W-1:0]    dist_sq;
   logic                hit;

   // handshakes
   assign accept = start && !busy;
   assign is_last = accept && req_last_item;
   assign has_room = (CMP_W'(cnt_ff) < MAX_CNT);
   assign cnt_next = CMP_W'(cnt_ff) + CMP_W'(has_room);
   assign ovf_next = ovf_ff || !has_room;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign j_next = CMP_W'(j_ff) + CMP_W'(1);
   assign i_next2 = CMP_W'(i_ff) + CMP_W'(2);
   assign mem_wdata = {req_center_x, req_center_y, req_center_z, req_radius};

   // sphere store
   pspc_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_SPHERES)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (cnt_ff[IDX_W-1:0]),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // axis magnitudes between entry i and entry j
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [COORD_W:0] ca;
         logic signed [COORD_W:0] cb;
         logic signed [COORD_W:0] d;
         ca = {item_i_ff[ITEM_W-1-a*COORD_W], item_i_ff[ITEM_W-1-a*COORD_W -: COORD_W]};
         cb = {mem_rdata[ITEM_W-1-a*COORD_W], mem_rdata[ITEM_W-1-a*COORD_W -: COORD_W]};
         d = ca - cb;
         mag[a] = d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
      end
   end

   // wrap lanes, one per axis
   for (genvar g = 0; g < 3; g++) begin : g_lane
      pspc_wrap u_wrap (
         .clock   (clock),
         .reset   (reset),
         .load    (wrap_load),
         .mag     (mag[g]),
         .box_len (box_ff),
         .done    (done[g]),
         .wrapped (wrapped[g])
      );
   end

   // distance against radius sum
   assign dist_sq = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   assign hit = (dist_sq < SUM_W'(rsq_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_last && !ovf_next && (cnt_next >= CMP_W'(2))) begin
               state_in = ST_READ_I;
            end
         end
         ST_READ_I:  state_in = ST_READ_J;
         ST_READ_J:  state_in = ST_DIFF;
         ST_FETCH_J: state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_WRAP;
         ST_WRAP: begin
            if (done[0]) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE:  state_in = ST_COMPARE;
         ST_COMPARE: begin
            priority if (hit) begin
               state_in = ST_IDLE;
            end else if (j_next < CMP_W'(cnt_ff)) begin
               state_in = ST_FETCH_J;
            end else if (i_next2 < CMP_W'(cnt_ff)) begin
               state_in = ST_READ_I;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and register updates
   always_comb begin
      busy = (state_ff != ST_IDLE);
      mem_we = (state_ff == ST_IDLE) && accept && has_room;
      mem_raddr = (state_ff == ST_READ_I) ? i_ff : j_ff;
      wrap_load = (state_ff == ST_DIFF);
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      i_in = i_ff;
      j_in = j_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_first_in = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_next[CNT_W-1:0];
               ovf_in = ovf_next;
               if (is_last) begin
                  i_in = '0;
                  j_in = IDX_W'(1);
                  rsp_first_in = '0;
                  rsp_second_in = '0;
                  if (ovf_next) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = STATUS_FULL;
                     cnt_in = '0;
                     ovf_in = 1'b0;
                  end else if (cnt_next < CMP_W'(2)) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = STATUS_NONE;
                     cnt_in = '0;
                  end
               end
            end
         end
         ST_COMPARE: begin
            priority if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_HIT;
               rsp_first_in = IDXO_W'(i_ff);
               rsp_second_in = IDXO_W'(j_ff);
               cnt_in = '0;
            end else if (j_next < CMP_W'(cnt_ff)) begin
               j_in = IDX_W'(j_next);
            end else if (i_next2 < CMP_W'(cnt_ff)) begin
               i_in = IDX_W'(CMP_W'(i_ff) + CMP_W'(1));
               j_in = IDX_W'(i_next2);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_NONE;
               rsp_first_in = '0;
               rsp_second_in = '0;
               cnt_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         box_ff <= BOX_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr && (paddr == {REG_BOX_LENGTH, 2'b00})) begin
            box_ff <= pwdata[BOX_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      if (state_ff == ST_READ_J) begin
         item_i_ff <= mem_rdata;
      end
      if (state_ff == ST_DIFF) begin
         rsum_ff <= RSUM_W'(item_i_ff[RADIUS_W-1:0]) + RSUM_W'(mem_rdata[RADIUS_W-1:0]);
      end
      if (state_ff == ST_SQUARE) begin
         for (int a = 0; a < 3; a++) begin
            sq_ff[a] <= SQ_W'(wrapped[a] * wrapped[a]);
         end
         rsq_ff <= RSQ_W'(rsum_ff * rsum_ff);
      end
   end

   // register read port
   assign pready = 1'b1;
   assign prdata = (paddr == {REG_BOX_LENGTH, 2'b00}) ? 32'(box_ff) : '0;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_second_index = rsp_second_ff;

   // the walk always looks at an ordered pair of loaded entries
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> (i_ff < j_ff) && (CMP_W'(j_ff) < CMP_W'(cnt_ff)))
      else $error("pair walk out of order");

   // the axis lanes run in lock step
   a_lane_sync: assert property (@(posedge clock) disable iff (reset)
      (done[0] == done[1]) && (done[1] == done[2]))
      else $error("wrap lanes out of step");

   // the store is written only while loading
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE) && (CMP_W'(cnt_ff) < MAX_CNT))
      else $error("store written outside loading");

   // a result clears the set
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |=> (cnt_ff == '0) && !ovf_ff)
      else $error("set not cleared after result");
endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the periodic sphere overlap check core
module testbench;
   import pspc_pkg::*;

   localparam int STORE_DEPTH = MAX_SPHERES_DEF;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {
      JOB_SPHERE,
      JOB_BOX_WRITE,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [RADIUS_W-1:0] radius;
      logic last;
      logic [BOX_W-1:0] box;
   } job_type;

   typedef struct {
      logic [1:0] status;
      logic [IDXO_W-1:0] first;
      logic [IDXO_W-1:0] second;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic signed [COORD_W-1:0] req_center_z = '0;
   logic [RADIUS_W-1:0] req_radius = '0;
   logic req_last_item = 1'b0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [IDXO_W-1:0] rsp_first_index;
   logic [IDXO_W-1:0] rsp_second_index;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   periodic_sphere_overlap_check_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z), .req_radius(req_radius),
      .req_last_item(req_last_item), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_first_index(rsp_first_index),
      .rsp_second_index(rsp_second_index), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   job_type pending_jobs[$];
   verdict_type expected_verdicts[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet_tail = 1'b0;

   // predictor copy of the sphere store and box register
   logic signed [COORD_W-1:0] pred_x[STORE_DEPTH];
   logic signed [COORD_W-1:0] pred_y[STORE_DEPTH];
   logic signed [COORD_W-1:0] pred_z[STORE_DEPTH];
   logic [RADIUS_W-1:0] pred_r[STORE_DEPTH];
   int pred_count = 0;
   bit pred_full = 1'b0;
   logic [BOX_W-1:0] pred_box = BOX_RESET;

   // minimum-image magnitude of a - b, rounding half away from zero
   function automatic longint unsigned image_gap(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
      longint d;
      longint unsigned m, q, len;
      d = longint'(a) - longint'(b);
      m = (d < 0) ? longint'(-d) : longint'(d);
      len = pred_box;
      if (len == 0) return m;
      q = (2 * m + len) / (2 * len);
      if (q * len >= m) return q * len - m;
      return m - q * len;
   endfunction

   // store one sphere; a last sphere closes the set and yields a verdict
   function automatic void absorb_sphere(job_type s);
      verdict_type v;
      longint unsigned dx, dy, dz, rs;
      bit hit;
      v = '{STATUS_NONE, '0, '0};
      hit = 1'b0;
      if (pred_count < STORE_DEPTH) begin
         pred_x[pred_count] = s.x;
         pred_y[pred_count] = s.y;
         pred_z[pred_count] = s.z;
         pred_r[pred_count] = s.radius;
         pred_count++;
      end else begin
         pred_full = 1'b1;
      end
      if (!s.last) return;
      if (pred_full) begin
         v.status = STATUS_FULL;
      end else begin
         for (int i = 0; i < pred_count && !hit; i++) begin
            for (int j = i + 1; j < pred_count && !hit; j++) begin
               dx = image_gap(pred_x[i], pred_x[j]);
               dy = image_gap(pred_y[i], pred_y[j]);
               dz = image_gap(pred_z[i], pred_z[j]);
               rs = longint'(pred_r[i]) + longint'(pred_r[j]);
               if (dx * dx + dy * dy + dz * dz < rs * rs) begin
                  hit = 1'b1;
                  v.status = STATUS_HIT;
                  v.first = i[IDXO_W-1:0];
                  v.second = j[IDXO_W-1:0];
               end
            end
         end
      end
      expected_verdicts.insert(expected_verdicts.size(), v);
      pred_count = 0;
      pred_full = 1'b0;
   endfunction

   // driver: spheres, box writes and drain points in queue order
   int gap_left = 0;
   int settle = 0;
   int csr_step = 0;
   job_type current;
   always @(posedge clock) begin
      job_type j;
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) absorb_sphere(current);
         next_start = 1'b0;
         if (csr_step == 1) begin
            penable <= 1'b1;
            csr_step = 2;
         end else if (csr_step == 2) begin
            if (pready) pred_box = pwdata[BOX_W-1:0];
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            csr_step = 0;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_jobs.size() > 0) begin
            j = pending_jobs[0];
            if (j.kind == JOB_SPHERE) begin
               void'(pending_jobs.pop_front());
               current = j;
               req_center_x <= j.x;
               req_center_y <= j.y;
               req_center_z <= j.z;
               req_radius <= j.radius;
               req_last_item <= j.last;
               next_start = 1'b1;
               if (!quiet_tail && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 5);
            end else if (expected_verdicts.size() == 0 && !busy && !start) begin
               // block is idle: let it settle before touching the register
               if (settle < SETTLE_CYCLES) begin
                  settle++;
               end else begin
                  settle = 0;
                  void'(pending_jobs.pop_front());
                  if (j.kind == JOB_BOX_WRITE) begin
                     psel <= 1'b1;
                     pwrite <= 1'b1;
                     paddr <= {REG_BOX_LENGTH, 2'b00};
                     pwdata <= {{(32 - BOX_W){1'b0}}, j.box};
                     csr_step = 1;
                  end
               end
            end else begin
               settle = 0;
            end
         end
         start <= next_start;
      end
   end

   // monitor: every result strobe is checked against the oldest verdict
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d first %0d second %0d",
                        rsp_status, rsp_first_index, rsp_second_index);
         end else begin
            v = expected_verdicts.pop_front();
            if (rsp_status !== v.status || rsp_first_index !== v.first ||
                rsp_second_index !== v.second) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                           v.status, v.first, v.second,
                           rsp_status, rsp_first_index, rsp_second_index);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word, result or register write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pwrite))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   int sphere_total = 0;
   logic [BOX_W-1:0] gen_box = BOX_RESET;

   task automatic add_sphere(int x, int y, int z, int r, bit last);
      job_type j;
      j.kind = JOB_SPHERE;
      j.x = x[COORD_W-1:0];
      j.y = y[COORD_W-1:0];
      j.z = z[COORD_W-1:0];
      j.radius = r[RADIUS_W-1:0];
      j.last = last;
      j.box = '0;
      pending_jobs.insert(pending_jobs.size(), j);
      sphere_total++;
   endtask

   task automatic add_marker(job_kind_type kind, logic [BOX_W-1:0] box);
      job_type j;
      j = '{kind, '0, '0, '0, '0, 1'b0, box};
      pending_jobs.insert(pending_jobs.size(), j);
      if (kind == JOB_BOX_WRITE) gen_box = box;
   endtask

   // coordinate near the box scale, or anywhere in range
   function automatic int pick_coord();
      int span;
      span = (gen_box > 2) ? int'(gen_box) : 4;
      if ($urandom_range(0, 4) == 0) return int'($urandom);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic int pick_radius();
      int span;
      span = int'(gen_box) / 4 + 1;
      if (span > 1048575) span = 1048575;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1048575);
         1: return 0;
         default: return $urandom_range(0, span);
      endcase
   endfunction

   task automatic add_random_set(int n);
      for (int k = 0; k < n; k++)
         add_sphere(pick_coord(), pick_coord(), pick_coord(), pick_radius(), k == n - 1);
   endtask

   initial begin
      int n;
      // single sphere, then coincident zero-radius pair
      add_sphere(0, 0, 0, 100, 1);
      add_sphere(5, 5, 5, 0, 0);
      add_sphere(5, 5, 5, 0, 1);
      // field extremes, wrapped by the default box
      add_sphere(-8388608, -8388608, -8388608, 1048575, 0);
      add_sphere(8388607, 8388607, 8388607, 1048575, 1);
      add_sphere(-1, 8388607, -8388608, 0, 0);
      add_sphere(0, 0, 0, 0, 1);
      // overlap found only at the last pair
      add_sphere(0, 0, 0, 10, 0);
      add_sphere(3000, 0, 0, 10, 0);
      add_sphere(3015, 0, 0, 10, 1);
      // overlap across the periodic boundary
      add_sphere(12700, 0, 0, 200, 0);
      add_sphere(-12700, 0, 0, 200, 1);
      // full row walk: only spheres 0 and 255 overlap
      add_sphere(0, 0, 0, 256, 0);
      for (int k = 1; k < 255; k++) add_sphere(12800, 12800, 12800, 0, 0);
      add_sphere(0, 0, 0, 1, 1);
      // store full: last sphere dropped, then one past it
      for (int k = 0; k < 256; k++) add_sphere(k, 0, 0, 0, 0);
      add_sphere(0, 0, 0, 0, 1);
      for (int k = 0; k < 258; k++) add_sphere(0, k, 0, 0, k == 257);
      // box extremes
      add_marker(JOB_BOX_WRITE, 23'd1);
      add_sphere(0, 0, 0, 1, 0);
      add_sphere(1000, 77, -3, 1, 1);
      add_marker(JOB_BOX_WRITE, 23'h7FFFFF);
      add_sphere(-8388608, 0, 0, 300, 0);
      add_sphere(8388607, 0, 0, 300, 1);
      add_marker(JOB_DRAIN, '0);
      add_marker(JOB_BOX_WRITE, BOX_RESET);

      // random sets, with box changes between them
      while (sphere_total < 1900) begin
         if ($urandom_range(0, 9) == 0) begin
            add_marker(JOB_DRAIN, '0);
            case ($urandom_range(0, 3))
               0: add_marker(JOB_BOX_WRITE, 23'd1);
               1: add_marker(JOB_BOX_WRITE, 23'h7FFFFF);
               2: add_marker(JOB_BOX_WRITE, BOX_RESET);
               default: add_marker(JOB_BOX_WRITE, $urandom_range(1, 23'h7FFFFF));
            endcase
         end
         case ($urandom_range(0, 39))
            0: n = 1;
            1: n = $urandom_range(20, 40);
            default: n = $urandom_range(2, 10);
         endcase
         add_random_set(n);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_jobs.size() < 250);
      quiet_tail = 1'b1;
      // sample between edges so every update of the edge has settled
      do @(negedge clock);
      while (!(pending_jobs.size() == 0 && expected_verdicts.size() == 0 &&
               !start && !busy && csr_step == 0));
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ periodic_sphere_overlap_check_core.f @@
hw/rtl/pspc_pkg.sv
hw/rtl/pspc_ram.sv
hw/rtl/pspc_wrap.sv
hw/rtl/periodic_sphere_overlap_check_core.sv
sim/testbench.sv
